// ===== hw/rtl/ssdt_pkg.sv =====
// ----------------------------------------------------------------------------
// ssdt_pkg
// Types and constants shared by the scan-line span depth test unit.
// ----------------------------------------------------------------------------
package ssdt_pkg;

    // configuration port
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [1:0] {
        REG_LINE_WIDTH    = 2'd0,
        REG_CLEAR_DEPTH   = 2'd1,
        REG_BACKGROUND_ID = 2'd2
    } t_reg_index;

    localparam logic [10:0]        LINE_WIDTH_RST    = 11'd1024;
    localparam logic signed [31:0] CLEAR_DEPTH_RST   = 32'sh8000_0000;
    localparam logic [15:0]        BACKGROUND_ID_RST = 16'd0;

    localparam logic signed [31:0] DEPTH_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] DEPTH_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_SPAN  = 2'd1,
        OP_READ  = 2'd2
    } t_opcode;

    typedef struct packed {
        t_opcode            opcode;
        logic [9:0]         x_left;
        logic [9:0]         x_right;
        logic signed [31:0] z_start;
        logic signed [31:0] z_step;
        logic [15:0]        polygon_id;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pixel_depth;
        logic [15:0]        pixel_id;
    } t_out_item;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_SPAN,
        S_RD_ISSUE,
        S_RD_DATA
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the accepted item
        logic fill_load;   // take fill values from the registers, restart sweep
        logic sweep_step;  // write one fill entry
        logic span_step;   // issue one span pixel
        logic rd_issue;    // issue the pixel read
        logic out_load;    // load the output register
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        t_opcode opcode;
        logic    span_empty;
        logic    span_last;
        logic    sweep_last;
        logic    out_free;
    } t_dp_stat;

endpackage

// ===== hw/rtl/ssdt_ram.sv =====
// ----------------------------------------------------------------------------
// ssdt_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ssdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/ssdt_regs.sv =====
// ----------------------------------------------------------------------------
// ssdt_regs
// APB configuration registers: line width, clear depth, background id.
// ----------------------------------------------------------------------------
module ssdt_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssdt_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [ssdt_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [ssdt_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready,
    output logic [10:0]                         o_line_width,
    output logic signed [31:0]                  o_clear_depth,
    output logic [15:0]                         o_background_id
);

    logic [10:0]        r_line_width;
    logic signed [31:0] r_clear_depth;
    logic [15:0]        r_background_id;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width    <= ssdt_pkg::LINE_WIDTH_RST;
            r_clear_depth   <= ssdt_pkg::CLEAR_DEPTH_RST;
            r_background_id <= ssdt_pkg::BACKGROUND_ID_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                ssdt_pkg::REG_LINE_WIDTH:    r_line_width    <= pwdata[10:0];
                ssdt_pkg::REG_CLEAR_DEPTH:   r_clear_depth   <= $signed(pwdata);
                ssdt_pkg::REG_BACKGROUND_ID: r_background_id <= pwdata[15:0];
                default: ;  // unmapped address, write dropped
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            ssdt_pkg::REG_LINE_WIDTH:    prdata = {21'd0, r_line_width};
            ssdt_pkg::REG_CLEAR_DEPTH:   prdata = r_clear_depth;
            ssdt_pkg::REG_BACKGROUND_ID: prdata = {16'd0, r_background_id};
            default:                     prdata = '0;
        endcase
    end

    assign o_line_width    = r_line_width;
    assign o_clear_depth   = r_clear_depth;
    assign o_background_id = r_background_id;

endmodule

// ===== hw/rtl/ssdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssdt_ctrl
// Sequencer: reset fill pass, clear sweep, span walk and pixel read.
// ----------------------------------------------------------------------------
module ssdt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ssdt_pkg::t_dp_stat i_stat,
    output ssdt_pkg::t_dp_cmd  o_cmd
);

    ssdt_pkg::t_state r_state;
    ssdt_pkg::t_state n_state;
    logic             accept;

    assign o_in_stall = (r_state != ssdt_pkg::S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ssdt_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ssdt_pkg::S_INIT, ssdt_pkg::S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = ssdt_pkg::S_IDLE;
                end
            end
            ssdt_pkg::S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    case (i_stat.opcode)
                        ssdt_pkg::OP_CLEAR: begin
                            o_cmd.fill_load = 1'b1;
                            n_state         = ssdt_pkg::S_CLEAR;
                        end
                        ssdt_pkg::OP_SPAN: begin
                            if (!i_stat.span_empty) begin
                                n_state = ssdt_pkg::S_SPAN;
                            end
                        end
                        ssdt_pkg::OP_READ: n_state = ssdt_pkg::S_RD_ISSUE;
                        default: ;  // unused opcode, dropped
                    endcase
                end
            end
            ssdt_pkg::S_SPAN: begin
                o_cmd.span_step = 1'b1;
                if (i_stat.span_last) begin
                    n_state = ssdt_pkg::S_IDLE;
                end
            end
            ssdt_pkg::S_RD_ISSUE: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = ssdt_pkg::S_RD_DATA;
            end
            ssdt_pkg::S_RD_DATA: begin
                // read data holds in the RAM until the output slot frees
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ssdt_pkg::S_IDLE;
                end
            end
            default: n_state = ssdt_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/ssdt_dp.sv =====
// ----------------------------------------------------------------------------
// ssdt_dp
// Datapath: depth and id line RAMs, span accumulator, depth compare,
// fill sweep counter and output register.
// ----------------------------------------------------------------------------
module ssdt_dp #(
    parameter int LINE_PIXELS = 1024,
    parameter int ID_BITS     = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ssdt_pkg::t_dp_cmd   i_cmd,
    output ssdt_pkg::t_dp_stat  o_stat,
    input  ssdt_pkg::t_in_item  i_in_data,
    input  logic [10:0]         i_line_width,
    input  logic signed [31:0]  i_clear_depth,
    input  logic [15:0]         i_background_id,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ssdt_pkg::t_out_item o_out_data
);

    localparam int AW = $clog2(LINE_PIXELS);
    localparam int WW = ($clog2(LINE_PIXELS + 1) > 11) ? $clog2(LINE_PIXELS + 1) : 11;
    localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_PIXELS - 1);

    // item registers
    logic [9:0]         r_x;
    logic [9:0]         r_xr;
    logic signed [31:0] r_z;
    logic signed [31:0] r_dz;
    logic [ID_BITS-1:0] r_id;
    logic               r_rd_ok;

    // fill sweep
    logic [AW-1:0]      r_sweep_addr;
    logic signed [31:0] r_fill_depth;
    logic [ID_BITS-1:0] r_fill_id;

    // compare stage
    logic               r_p_valid;
    logic [AW-1:0]      r_p_addr;
    logic signed [31:0] r_p_z;

    // output register
    logic                r_out_valid;
    ssdt_pkg::t_out_item r_out_data;

    logic [WW-1:0]        eff_w;
    logic [WW-1:0]        x_ext;
    logic                 x_in_range;
    logic [AW+9:0]        x_pad;
    logic [AW-1:0]        x_addr;
    logic [ID_BITS+15:0]  pid_pad;
    logic [ID_BITS+15:0]  bg_pad;
    logic [ID_BITS+15:0]  rid_pad;
    logic signed [32:0]   z_sum;
    logic signed [31:0]   z_next;
    logic                 pipe_we;
    logic                 we;
    logic [AW-1:0]        waddr;
    logic [31:0]          wdepth;
    logic [ID_BITS-1:0]   wid;
    logic                 re;
    logic [31:0]          rdepth;
    logic [ID_BITS-1:0]   rid;
    logic                 out_free;

    // pixel in use: x below min(line_width, LINE_PIXELS)
    assign eff_w      = (WW'(i_line_width) > WW'(LINE_PIXELS)) ? WW'(LINE_PIXELS)
                                                               : WW'(i_line_width);
    assign x_ext      = WW'(r_x);
    assign x_in_range = x_ext < eff_w;
    assign x_pad      = {{AW{1'b0}}, r_x};
    assign x_addr     = x_pad[AW-1:0];

    // id width adaption
    assign pid_pad = {{ID_BITS{1'b0}}, i_in_data.polygon_id};
    assign bg_pad  = {{ID_BITS{1'b0}}, i_background_id};
    assign rid_pad = {16'd0, rid};

    // saturating depth accumulator
    assign z_sum  = {r_z[31], r_z} + {r_dz[31], r_dz};
    assign z_next = (z_sum[32] != z_sum[31]) ?
                    (z_sum[32] ? ssdt_pkg::DEPTH_MIN : ssdt_pkg::DEPTH_MAX) :
                    z_sum[31:0];

    // item capture and span walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_x  <= i_in_data.x_left;
            r_xr <= i_in_data.x_right;
            r_z  <= i_in_data.z_start;
            r_dz <= i_in_data.z_step;
            r_id <= pid_pad[ID_BITS-1:0];
        end else if (i_cmd.span_step) begin
            r_x <= r_x + 10'd1;
            r_z <= z_next;
        end
        if (i_cmd.rd_issue) begin
            r_rd_ok <= x_in_range;
        end
        if (i_cmd.span_step) begin
            r_p_addr <= x_addr;
            r_p_z    <= r_z;
        end
    end

    // compare stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.span_step && x_in_range;
        end
    end

    // fill sweep; reset values give the power-on pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_addr <= '0;
            r_fill_depth <= ssdt_pkg::CLEAR_DEPTH_RST;
            r_fill_id    <= '0;
        end else if (i_cmd.fill_load) begin
            r_sweep_addr <= '0;
            r_fill_depth <= i_clear_depth;
            r_fill_id    <= bg_pad[ID_BITS-1:0];
        end else if (i_cmd.sweep_step) begin
            r_sweep_addr <= r_sweep_addr + AW'(1);
        end
    end

    // RAM ports: sweep writes or depth-test winner
    assign pipe_we = r_p_valid && (r_p_z > $signed(rdepth));
    assign we      = i_cmd.sweep_step || pipe_we;
    assign waddr   = i_cmd.sweep_step ? r_sweep_addr : r_p_addr;
    assign wdepth  = i_cmd.sweep_step ? r_fill_depth : r_p_z;
    assign wid     = i_cmd.sweep_step ? r_fill_id : r_id;
    assign re      = i_cmd.span_step || i_cmd.rd_issue;

    ssdt_ram #(
        .WIDTH (32),
        .DEPTH (LINE_PIXELS)
    ) u_depth_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdepth),
        .i_re    (re),
        .i_raddr (x_addr),
        .o_rdata (rdepth)
    );

    ssdt_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (LINE_PIXELS)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wid),
        .i_re    (re),
        .i_raddr (x_addr),
        .o_rdata (rid)
    );

    // output register
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.pixel_depth <= r_rd_ok ? $signed(rdepth) : 32'sd0;
            r_out_data.pixel_id    <= r_rd_ok ? rid_pad[15:0] : 16'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // status
    assign o_stat.opcode     = i_in_data.opcode;
    assign o_stat.span_empty = i_in_data.x_right < i_in_data.x_left;
    assign o_stat.span_last  = (r_x == r_xr);
    assign o_stat.sweep_last = (r_sweep_addr == LAST_ADDR);
    assign o_stat.out_free   = out_free;

    // sweep writes never collide with a depth-test write
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.sweep_step && r_p_valid))
        else $error("fill sweep overlaps a span write");

    // a compare stage entry comes only from an issued span pixel
    a_pipe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_valid |-> $past(i_cmd.span_step))
        else $error("compare stage valid without span issue");

    // a result is never loaded over one that is still stalled
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !i_cmd.out_load)
        else $error("output register overwritten while stalled");

    // a pixel read is issued for one cycle, never together with a load
    a_read_issue_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> !i_cmd.out_load ##1 !i_cmd.rd_issue)
        else $error("read issue overlaps a load or repeats");

endmodule

// ===== hw/rtl/scanline_span_depth_test_unit.sv =====
// ----------------------------------------------------------------------------
// scanline_span_depth_test_unit
// One scan line of depth and polygon-id buffers with a per-pixel depth test.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one item at a
// time. A clear item fills every pixel with clear_depth and background_id.
// A span item walks x_left to x_right, one pixel per cycle through the
// depth RAM read and compare stage; an empty span or an unused opcode is
// taken without a walk. A read item goes through the read issue and data
// states to the output register (o_out_valid / i_out_stall / o_out_data).
// The sequencer holds the line RAMs for the whole item.
// When the receiver stalls, the result waits in the output register; the
// next item is accepted meanwhile, and a following read waits in its data
// state until the output register is free.
// After reset the unit runs a fill pass that writes the reset clear depth
// and id; o_in_stall stays high during it, while the APB port (pready
// always high) takes register writes as usual.
// ----------------------------------------------------------------------------
module scanline_span_depth_test_unit #(
    parameter int LINE_PIXELS = 1024,
    parameter int ID_BITS     = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  ssdt_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output ssdt_pkg::t_out_item                 o_out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ssdt_pkg::CFG_ADDR_BITS-1:0]  paddr,
    input  logic [ssdt_pkg::CFG_DATA_BITS-1:0]  pwdata,
    output logic [ssdt_pkg::CFG_DATA_BITS-1:0]  prdata,
    output logic                                pready
);

    logic [10:0]        line_width;
    logic signed [31:0] clear_depth;
    logic [15:0]        background_id;
    ssdt_pkg::t_dp_cmd  cmd;
    ssdt_pkg::t_dp_stat stat;

    ssdt_regs u_regs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_line_width    (line_width),
        .o_clear_depth   (clear_depth),
        .o_background_id (background_id)
    );

    ssdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ssdt_dp #(
        .LINE_PIXELS (LINE_PIXELS),
        .ID_BITS     (ID_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_data       (i_in_data),
        .i_line_width    (line_width),
        .i_clear_depth   (clear_depth),
        .i_background_id (background_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_data      (o_out_data)
    );

endmodule
